@@ sv/dia_pkg.sv @@
// Shared types and constants for the descriptor ID allocator.
// Used by descriptor_id_allocator and its port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dia_pkg;

	// default geometry
	localparam int DEF_MAX_IDS   = 1024;
	localparam int DEF_WORD_BITS = 64;

	// fixed field widths
	localparam int MODE_W   = 2;
	localparam int DESC_W   = 10;
	localparam int STATUS_W = 2;
	localparam int LIMIT_W  = 11;
	localparam int TDATA_W  = 16;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

	// operation codes carried on s_tuser
	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_SET     = 2'd2,
		MODE_QUERY   = 2'd3
	} mode_t;

	// result codes carried on m_tuser
	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

endpackage

`default_nettype wire

@@ sv/descriptor_id_allocator.sv @@
// Lowest-free ID allocator: sequencer, open / close-on-exec word memories,
// full-word summary and next-free hint. Depends on dia_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One request at a time. An allocate walks the words from max(descriptor, hint):
// a word whose full bit is set is skipped without a read; a word that is read
// and has no free bit at or above the start offset takes a read step and a
// find step; the final word takes a read step, a find/write step and a result
// step. An in-range release, set or query takes one read-modify-write of a
// single word: accept, update and result steps. An out-of-range one, and an
// allocate whose start is already past the table, go from accept straight to
// the result step. The result step repeats while the output register still
// holds an untaken result. The pace of both kinds of request is set by the
// single read and write port of each word memory and by the word-by-word walk.
// After reset the block clears both memories, one word per cycle, before it
// takes a request.
// id_limit may be written at any idle time; values above MAX_IDS act as MAX_IDS.
// WORD_BITS must be a power of two.
module descriptor_id_allocator #(
	parameter int MAX_IDS   = dia_pkg::DEF_MAX_IDS,
	parameter int WORD_BITS = dia_pkg::DEF_WORD_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// request: tuser = mode; tdata = descriptor[9:0], exec_close_flag[10], zero pad
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [dia_pkg::TDATA_W-1:0]   s_tdata,
	input  wire logic [dia_pkg::MODE_W-1:0]    s_tuser,
	// result: tuser = status; tdata = id_out[9:0], is_open[10],
	// exec_close_state[11], zero pad
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [dia_pkg::TDATA_W-1:0]        m_tdata,
	output logic [dia_pkg::STATUS_W-1:0]       m_tuser,
	// id_limit write
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [dia_pkg::LIMIT_W-1:0]   cfg_data
);
	import dia_pkg::*;

	localparam int WB      = WORD_BITS;
	localparam int NWORDS  = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
	localparam int OFF_W   = $clog2(WORD_BITS);
	localparam int WIDX_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int WPTR_W  = $clog2(NWORDS + 1);
	localparam int CNT_W   = $clog2(MAX_IDS + 1);
	localparam int CW      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int LAST_BITS = MAX_IDS - (NWORDS - 1) * WORD_BITS;
	localparam logic [WORD_BITS-1:0] LAST_MASK =
		{WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
	localparam logic [CW-1:0]     MAX_C   = CW'(MAX_IDS);
	localparam logic [WPTR_W-1:0] NW_C    = WPTR_W'(NWORDS);
	localparam logic [WPTR_W-1:0] LAST_W  = WPTR_W'(NWORDS - 1);
	localparam logic [WIDX_W-1:0] LAST_IX = WIDX_W'(NWORDS - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FIND,
		S_RMW,
		S_DONE
	} state_t;

	// lowest set bit of a word
	function automatic logic [OFF_W-1:0] low_one(input logic [WB-1:0] v);
		logic [OFF_W-1:0] r;
		r = '0;
		for (int i = WB - 1; i >= 0; i--) begin
			if (v[i]) r = OFF_W'(i);
		end
		return r;
	endfunction

	state_t              state_q;
	logic [WIDX_W-1:0]   clr_q;
	logic [WPTR_W-1:0]   w_q;
	logic [OFF_W-1:0]    off_q;
	mode_t               mode_q;
	logic                flag_q;
	logic [CW-1:0]       desc_q;
	logic [CW-1:0]       hint_q;
	logic [LIMIT_W-1:0]  id_limit_q;
	logic [NWORDS-1:0]   full_q;

	status_t             res_status_q;
	logic [DESC_W-1:0]   res_id_q;
	logic                res_open_q;
	logic                res_exec_q;

	logic                m_valid_q;
	status_t             m_status_q;
	logic [DESC_W-1:0]   m_id_q;
	logic                m_open_q;
	logic                m_exec_q;

	logic [WB-1:0]       open_mem [NWORDS];
	logic [WB-1:0]       exec_mem [NWORDS];
	logic [WB-1:0]       open_rd_q;
	logic [WB-1:0]       exec_rd_q;

	logic                accept_c;
	mode_t               in_mode_c;
	logic [CW-1:0]       in_desc_c;
	logic [CW-1:0]       from_c;
	logic [CW-1:0]       limit_c;
	logic [CW-1:0]       f_c;
	logic [WB-1:0]       vmask_c;
	logic [WB-1:0]       cand_c;
	logic                hit_c;
	logic                alloc_ok_c;
	logic [OFF_W-1:0]    pos_c;
	logic [OFF_W-1:0]    sel_pos_c;
	logic [WB-1:0]       bit_c;
	logic [WB-1:0]       new_open_c;
	logic [WB-1:0]       new_exec_c;
	logic                scan_end_c;
	logic                scan_full_c;
	logic                mem_we_c;
	logic [WIDX_W-1:0]   wa_c;
	logic [WB-1:0]       open_wd_c;
	logic [WB-1:0]       exec_wd_c;
	logic                rd_en_c;
	logic [WIDX_W-1:0]   ra_c;
	logic                out_free_c;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept_c  = s_tvalid && s_tready;
	assign in_mode_c = mode_t'(s_tuser);
	assign in_desc_c = CW'(s_tdata[DESC_W-1:0]);
	assign from_c    = (in_desc_c < hint_q) ? hint_q : in_desc_c;
	assign limit_c   = CW'(id_limit_q);
	assign out_free_c = !m_valid_q || m_tready;

	// word search and update datapath
	always_comb begin
		vmask_c     = (w_q == LAST_W) ? LAST_MASK : {WB{1'b1}};
		cand_c      = ~open_rd_q & vmask_c & ({WB{1'b1}} << off_q);
		hit_c       = |cand_c;
		pos_c       = low_one(cand_c);
		f_c         = (CW'(w_q) << OFF_W) | CW'(pos_c);
		alloc_ok_c  = hit_c && (f_c < limit_c);
		sel_pos_c   = (state_q == S_FIND) ? pos_c : off_q;
		bit_c       = WB'(1) << sel_pos_c;
		scan_end_c  = (w_q >= NW_C);
		scan_full_c = full_q[w_q[WIDX_W-1:0]];

		// open word after the operation
		if (state_q == S_FIND)
			new_open_c = open_rd_q | bit_c;
		else if (mode_q == MODE_RELEASE)
			new_open_c = open_rd_q & ~bit_c;
		else
			new_open_c = open_rd_q;

		// close-on-exec word after the operation
		if (state_q == S_FIND || mode_q == MODE_SET)
			new_exec_c = flag_q ? (exec_rd_q | bit_c) : (exec_rd_q & ~bit_c);
		else
			new_exec_c = exec_rd_q;

		mem_we_c  = 1'b0;
		wa_c      = w_q[WIDX_W-1:0];
		open_wd_c = new_open_c;
		exec_wd_c = new_exec_c;
		rd_en_c   = 1'b0;
		ra_c      = w_q[WIDX_W-1:0];
		unique case (state_q)
			S_CLEAR: begin
				mem_we_c  = 1'b1;
				wa_c      = clr_q;
				open_wd_c = '0;
				exec_wd_c = '0;
			end
			S_IDLE: begin
				rd_en_c = accept_c && (in_mode_c != MODE_ALLOC) && (in_desc_c < MAX_C);
				ra_c    = WIDX_W'(in_desc_c >> OFF_W);
			end
			S_SCAN: begin
				rd_en_c = !scan_end_c && !scan_full_c;
			end
			S_FIND: begin
				mem_we_c = alloc_ok_c;
			end
			S_RMW: begin
				mem_we_c = 1'b1;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// word memories: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we_c) begin
			open_mem[wa_c] <= open_wd_c;
			exec_mem[wa_c] <= exec_wd_c;
		end
		if (rd_en_c) begin
			open_rd_q <= open_mem[ra_c];
			exec_rd_q <= exec_mem[ra_c];
		end
	end

	// sequencer, summary, hint and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			w_q          <= '0;
			off_q        <= '0;
			mode_q       <= MODE_ALLOC;
			flag_q       <= 1'b0;
			desc_q       <= '0;
			hint_q       <= '0;
			id_limit_q   <= LIMIT_RESET;
			full_q       <= '0;
			res_status_q <= ST_OK;
			res_id_q     <= '0;
			res_open_q   <= 1'b0;
			res_exec_q   <= 1'b0;
			m_valid_q    <= 1'b0;
			m_status_q   <= ST_OK;
			m_id_q       <= '0;
			m_open_q     <= 1'b0;
			m_exec_q     <= 1'b0;
		end else begin
			if (cfg_valid) id_limit_q <= cfg_data;
			// the result cycle reloads the output register itself
			if (m_valid_q && m_tready && state_q != S_DONE) m_valid_q <= 1'b0;

			unique case (state_q)
				// zero both memories after reset
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IX) state_q <= S_IDLE;
				end

				// take a request, start the walk or the single-word update
				S_IDLE: begin
					if (accept_c) begin
						mode_q <= in_mode_c;
						flag_q <= s_tdata[DESC_W];
						desc_q <= in_desc_c;
						if (in_mode_c == MODE_ALLOC) begin
							w_q   <= WPTR_W'(from_c >> OFF_W);
							off_q <= from_c[OFF_W-1:0];
							if (from_c >= MAX_C) begin
								res_status_q <= ST_NO_FREE;
								res_id_q     <= '0;
								res_open_q   <= 1'b0;
								res_exec_q   <= 1'b0;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_SCAN;
							end
						end else begin
							w_q   <= WPTR_W'(in_desc_c >> OFF_W);
							off_q <= in_desc_c[OFF_W-1:0];
							if (in_desc_c >= MAX_C) begin
								res_status_q <= ST_RANGE;
								res_id_q     <= s_tdata[DESC_W-1:0];
								res_open_q   <= 1'b0;
								res_exec_q   <= 1'b0;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_RMW;
							end
						end
					end
				end

				// skip full words; read the first one that is not full
				S_SCAN: begin
					if (scan_end_c) begin
						res_status_q <= ST_NO_FREE;
						res_id_q     <= '0;
						res_open_q   <= 1'b0;
						res_exec_q   <= 1'b0;
						state_q      <= S_DONE;
					end else if (scan_full_c) begin
						w_q   <= WPTR_W'(w_q + 1'b1);
						off_q <= '0;
					end else begin
						state_q <= S_FIND;
					end
				end

				// pick the lowest free bit, or move on to the next word
				S_FIND: begin
					if (!hit_c) begin
						w_q     <= WPTR_W'(w_q + 1'b1);
						off_q   <= '0;
						state_q <= S_SCAN;
					end else begin
						if (alloc_ok_c) begin
							full_q[w_q[WIDX_W-1:0]] <= ((new_open_c & vmask_c) == vmask_c);
							if (desc_q <= hint_q) hint_q <= CW'(f_c + 1'b1);
							res_status_q <= ST_OK;
							res_id_q     <= DESC_W'(f_c);
							res_open_q   <= 1'b1;
							res_exec_q   <= flag_q;
						end else begin
							res_status_q <= ST_NO_FREE;
							res_id_q     <= '0;
							res_open_q   <= 1'b0;
							res_exec_q   <= 1'b0;
						end
						state_q <= S_DONE;
					end
				end

				// release, set or query on one word
				S_RMW: begin
					if (mode_q == MODE_RELEASE) begin
						full_q[w_q[WIDX_W-1:0]] <= 1'b0;
						if (desc_q < hint_q) hint_q <= desc_q;
					end
					res_status_q <= ST_OK;
					res_id_q     <= DESC_W'(desc_q);
					res_open_q   <= new_open_c[off_q];
					res_exec_q   <= new_exec_c[off_q];
					state_q      <= S_DONE;
				end

				// hand the result to the output register
				S_DONE: begin
					if (out_free_c) begin
						m_valid_q  <= 1'b1;
						m_status_q <= res_status_q;
						m_id_q     <= res_id_q;
						m_open_q   <= res_open_q;
						m_exec_q   <= res_exec_q;
						state_q    <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = TDATA_W'({m_exec_q, m_open_q, m_id_q});

endmodule

`default_nettype wire

@@ sv/dia_checker.sv @@
// Port-level checker for descriptor_id_allocator, attached by bind.
// Depends on dia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dia_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [dia_pkg::TDATA_W-1:0]   m_tdata,
	input wire logic [dia_pkg::STATUS_W-1:0]  m_tuser
);
	import dia_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one request at a time: busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// failed allocation reports zero id and flags
	a_nofree: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_NO_FREE) |-> (m_tdata[11:0] == 12'd0))
		else $error("no-free result carries data");

	// out-of-range target reports no flags
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_RANGE) |-> (m_tdata[11:10] == 2'd0))
		else $error("out-of-range result carries flags");

endmodule

bind descriptor_id_allocator dia_checker u_dia_checker (.*);

`default_nettype wire
